>>> hw/rtl/iirdf1_pkg.sv
// -----------------------------------------------------------------------------
// iirdf1_pkg - shared types and constants for the direct form I IIR filter
// Item and result payload structs, item kind codes, sequencer states and the
// fixed-point widths used by the filter datapath.
// -----------------------------------------------------------------------------
package iirdf1_pkg;

	// filter size
	localparam int MAX_ORDER  = 20;
	localparam int TAPS       = MAX_ORDER + 1;
	localparam int TAP_AW     = $clog2(TAPS);
	localparam int HIST_DEPTH = 32;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// fixed point: Q8.24 operands, Q16.48 products
	localparam int DATA_W = 32;
	localparam int FRAC_W = 24;
	localparam int PROD_W = 2 * DATA_W;
	// exact sum of up to two banks of products plus rounding bias
	localparam int ACC_W  = PROD_W + $clog2(2 * TAPS) + 1;

	// configuration registers
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FF_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_COUNT = 1'd1;

	// item kinds
	localparam logic [1:0] KIND_FILTER = 2'd0;
	localparam logic [1:0] KIND_LOAD   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// coefficient banks
	localparam logic BANK_FF = 1'b0;
	localparam logic BANK_FB = 1'b1;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] sample;
		logic                     coef_bank;
		logic [4:0]               coef_index;
		logic signed [DATA_W-1:0] coef_value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] filtered;
		logic                     saturated;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/iir_direct_form_one_filter_unit.sv
// -----------------------------------------------------------------------------
// iir_direct_form_one_filter_unit - direct form I IIR filter, Q8.24
// Item channel (item_valid/item_ready/item) takes filter, coefficient load and
// clear transactions; result channel (result_valid/result_ready/result) returns
// one transaction per filtered sample. cfg_we/cfg_index/cfg_data write the
// feedforward and feedback tap counts; the user must write them only while the
// block is idle, since the block itself does not enforce it.
// A filter transaction runs N = nff + nfb - 1 products through one shared
// 32x32 multiply-accumulate unit, one product per cycle; item_ready returns in
// the same cycle as the result becomes valid. The product rate is set by the
// single multiplier and the single read port on each coefficient and history
// store. Loads and clears produce no result and keep item_ready high.
// The result register holds a finished transaction while the receiver stalls;
// the block keeps taking loads, clears and a next sample meanwhile, and only
// a finished sample waits in its final state until the register frees up.
// Reset clears the coefficient and history valid bits, write pointer and the
// result valid flag, sets both tap counts to one; no clearing pass is needed.
// -----------------------------------------------------------------------------
module iir_direct_form_one_filter_unit
	import iirdf1_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	state_t state_q, state_nxt;

	// configuration
	logic [CNT_W-1:0] ff_cnt_q, fb_cnt_q;

	// coefficient and history stores with valid bits
	logic [DATA_W-1:0] ff_mem [TAPS];
	logic [DATA_W-1:0] fb_mem [TAPS];
	logic [DATA_W-1:0] xh_mem [HIST_DEPTH];
	logic [DATA_W-1:0] yh_mem [HIST_DEPTH];
	logic [TAPS-1:0]       ff_cv_q, fb_cv_q;
	logic [HIST_DEPTH-1:0] xh_v_q, yh_v_q;
	logic [HIST_AW-1:0]    wp_q;

	// per-sample context
	logic signed [DATA_W-1:0] sample_q;
	logic [TAP_AW-1:0]        ff_last_q, fb_last_q;
	logic                     iss_fb_q;
	logic [TAP_AW-1:0]        iss_k_q;

	// read, multiply and accumulate stages
	logic                     vld_s1, vld_s2;
	logic                     neg_s1, neg_s2;
	logic                     use_x_s1;
	logic [DATA_W-1:0]        coef_s1, hdata_s1;
	logic                     cv_s1, hv_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// result register
	logic    result_valid_q;
	result_t result_q;

	// control
	logic accept, acc_filter, issue_en, last_issue, done_fire;
	logic [CNT_W-1:0]   ff_cl, fb_cl;
	logic [HIST_AW-1:0] rd_pos;
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [ACC_W-1:0]  prod_ext;
	logic [ACC_W-FRAC_W-1:0]  shifted;
	logic [ACC_W-FRAC_W-DATA_W:0] top_bits;
	logic                     in_range;
	logic signed [DATA_W-1:0] y_val;

	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(TAPS);

	assign accept     = item_valid && item_ready;
	assign acc_filter = accept && (item.kind == KIND_FILTER);
	assign last_issue = iss_fb_q ? (iss_k_q == fb_last_q)
	                             : ((iss_k_q == ff_last_q) && (fb_last_q == '0));

	// tap counts limited to one through the full tap count
	always_comb begin
		ff_cl = ff_cnt_q;
		if (ff_cnt_q == '0) ff_cl = CNT_W'(1);
		else if (ff_cnt_q > CNT_MAX) ff_cl = CNT_MAX;
		fb_cl = fb_cnt_q;
		if (fb_cnt_q == '0) fb_cl = CNT_W'(1);
		else if (fb_cnt_q > CNT_MAX) fb_cl = CNT_MAX;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (acc_filter) state_nxt = ST_ISSUE;
			ST_ISSUE: if (last_issue) state_nxt = ST_DRAIN;
			ST_DRAIN: if (!vld_s1 && !vld_s2) state_nxt = ST_DONE;
			ST_DONE:  if (done_fire) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		issue_en   = 1'b0;
		done_fire  = 1'b0;
		case (state_q)
			ST_IDLE:  item_ready = 1'b1;
			ST_ISSUE: issue_en   = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done_fire  = !result_valid_q || result_ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_cnt_q <= CNT_W'(1);
			fb_cnt_q <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FF_COUNT: ff_cnt_q <= cfg_data;
				REG_FB_COUNT: fb_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits, write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_cv_q <= '0;
			fb_cv_q <= '0;
			xh_v_q  <= '0;
			yh_v_q  <= '0;
			wp_q    <= '0;
		end else begin
			if (accept && (item.kind == KIND_LOAD) && (item.coef_index <= 5'(MAX_ORDER))) begin
				if (item.coef_bank == BANK_FF) ff_cv_q[item.coef_index[TAP_AW-1:0]] <= 1'b1;
				else                           fb_cv_q[item.coef_index[TAP_AW-1:0]] <= 1'b1;
			end
			if (accept && (item.kind == KIND_CLEAR)) begin
				xh_v_q <= '0;
				yh_v_q <= '0;
				wp_q   <= '0;
			end else if (done_fire) begin
				xh_v_q[wp_q] <= 1'b1;
				yh_v_q[wp_q] <= 1'b1;
				wp_q         <= wp_q + HIST_AW'(1);
			end
		end
	end

	// coefficient stores
	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_LOAD) && (item.coef_index <= 5'(MAX_ORDER))) begin
			if (item.coef_bank == BANK_FF) ff_mem[item.coef_index[TAP_AW-1:0]] <= item.coef_value;
			else                           fb_mem[item.coef_index[TAP_AW-1:0]] <= item.coef_value;
		end
		if (issue_en) begin
			coef_s1 <= iss_fb_q ? fb_mem[iss_k_q] : ff_mem[iss_k_q];
			cv_s1   <= iss_fb_q ? fb_cv_q[iss_k_q] : ff_cv_q[iss_k_q];
		end
	end

	// history stores, newest entry one below the write pointer
	assign rd_pos = wp_q - HIST_AW'(iss_k_q);

	always_ff @(posedge clk) begin
		if (done_fire) begin
			xh_mem[wp_q] <= sample_q;
			yh_mem[wp_q] <= y_val;
		end
		if (issue_en) begin
			hdata_s1 <= iss_fb_q ? yh_mem[rd_pos] : xh_mem[rd_pos];
			hv_s1    <= iss_fb_q ? yh_v_q[rd_pos] : xh_v_q[rd_pos];
		end
	end

	// per-sample context and tap walk
	always_ff @(posedge clk) begin
		if (acc_filter) begin
			sample_q  <= item.sample;
			ff_last_q <= TAP_AW'(ff_cl - CNT_W'(1));
			fb_last_q <= TAP_AW'(fb_cl - CNT_W'(1));
			iss_fb_q  <= BANK_FF;
			iss_k_q   <= '0;
		end else if (issue_en) begin
			if (!iss_fb_q && (iss_k_q == ff_last_q)) begin
				iss_fb_q <= BANK_FB;
				iss_k_q  <= TAP_AW'(1);
			end else begin
				iss_k_q <= iss_k_q + TAP_AW'(1);
			end
		end
		if (issue_en) begin
			neg_s1   <= iss_fb_q;
			use_x_s1 <= !iss_fb_q && (iss_k_q == '0);
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue_en;
			vld_s2 <= vld_s1;
		end
	end

	// shared multiplier, unwritten entries read as zero
	assign mul_a = cv_s1 ? $signed(coef_s1) : '0;
	assign mul_b = use_x_s1 ? sample_q : (hv_s1 ? $signed(hdata_s1) : '0);

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		neg_s2  <= neg_s1;
	end

	// exact accumulation, seeded with the rounding bias
	assign prod_ext = ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (acc_filter) acc_q <= $signed(ROUND_BIAS);
		else if (vld_s2) acc_q <= neg_s2 ? (acc_q - prod_ext) : (acc_q + prod_ext);
	end

	// round by truncation after bias, then saturate
	assign shifted  = acc_q[ACC_W-1:FRAC_W];
	assign top_bits = shifted[ACC_W-FRAC_W-1:DATA_W-1];
	assign in_range = (&top_bits) || !(|top_bits);

	always_comb begin
		if (in_range)          y_val = $signed(shifted[DATA_W-1:0]);
		else if (acc_q[ACC_W-1]) y_val = {1'b1, {(DATA_W-1){1'b0}}};
		else                   y_val = {1'b0, {(DATA_W-1){1'b1}}};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (done_fire) result_valid_q <= 1'b1;
		else if (result_ready) result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			result_q.filtered  <= y_val;
			result_q.saturated <= !in_range;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> hw/rtl/iirdf1_checker.sv
// -----------------------------------------------------------------------------
// iirdf1_props - port-level checks for the direct form I IIR filter
// Watches the item and result channels and checks the sequencing that the
// filter shows at its ports.
// -----------------------------------------------------------------------------
module iirdf1_props
	import iirdf1_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic filter_acc, other_acc;

	assign filter_acc = item_valid && item_ready && (item.kind == KIND_FILTER);
	assign other_acc  = item_valid && item_ready && (item.kind != KIND_FILTER);

	// a sample transaction holds item_ready low after it is accepted
	a_filter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		filter_acc |=> !item_ready ##1 !item_ready ##1 !item_ready)
		else $error("item_ready returned too early after a sample transaction");

	// loads and clears leave item_ready high
	a_other_fast: assert property (@(posedge clk) disable iff (!arst_n)
		other_acc |=> item_ready)
		else $error("item_ready dropped after a load or clear transaction");

	// a waiting result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before it was taken");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

endmodule

bind iir_direct_form_one_filter_unit iirdf1_props u_iirdf1_props (.*);

>>> sim/iirdf1_checker.sv
// -----------------------------------------------------------------------------
// iirdf1_checker - result predictor and scoreboard for the DF-I IIR filter
// Watches the item, result and configuration ports of the filter unit, keeps
// its own copy of tap counts, coefficients, histories and write pointer, works
// out the expected output of every accepted sample and compares it field by
// field with each accepted result transaction.
// -----------------------------------------------------------------------------
module iirdf1_checker
	import iirdf1_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  item_t                item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   results_seen,
	output int                   saturations
);

	// predictor state
	logic [CNT_W-1:0]         ff_count_q;
	logic [CNT_W-1:0]         fb_count_q;
	logic signed [DATA_W-1:0] ff_coef [TAPS];
	logic signed [DATA_W-1:0] fb_coef [TAPS];
	logic signed [DATA_W-1:0] x_hist [HIST_DEPTH];
	logic signed [DATA_W-1:0] y_hist [HIST_DEPTH];
	logic [HIST_AW-1:0]       wr_ptr;
	result_t                  expected_q [$];
	int                       error_total;
	int                       result_total;
	int                       clip_total;

	// tap count actually used for a register value
	function automatic int taps_in_use(logic [CNT_W-1:0] c);
		if (c == '0)
			return 1;
		if (int'(c) > TAPS)
			return TAPS;
		return int'(c);
	endfunction

	// exact sum of products, round half up to Q8.24, then clip
	function automatic result_t filter_output(logic signed [DATA_W-1:0] x);
		logic signed [127:0]      acc;
		logic signed [127:0]      rounded;
		logic signed [PROD_W-1:0] prod;
		logic [HIST_AW-1:0]       pos;
		result_t                  r;
		int                       k;
		prod = ff_coef[0] * x;
		acc = prod;
		for (k = 1; k < taps_in_use(ff_count_q); k++) begin
			pos = wr_ptr - HIST_AW'(k);
			prod = ff_coef[k] * x_hist[pos];
			acc = acc + prod;
		end
		for (k = 1; k < taps_in_use(fb_count_q); k++) begin
			pos = wr_ptr - HIST_AW'(k);
			prod = fb_coef[k] * y_hist[pos];
			acc = acc - prod;
		end
		rounded = (acc + (128'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		if (rounded > 128'sh7FFF_FFFF) begin
			r.filtered = 32'h7FFF_FFFF;
			r.saturated = 1'b1;
		end else if (rounded < -128'sh8000_0000) begin
			r.filtered = 32'h8000_0000;
			r.saturated = 1'b1;
		end else begin
			r.filtered = rounded[DATA_W-1:0];
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	// track transactions on all ports
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int i;
		if (!arst_n) begin
			ff_count_q = CNT_W'(1);
			fb_count_q = CNT_W'(1);
			for (i = 0; i < TAPS; i++) begin
				ff_coef[i] = '0;
				fb_coef[i] = '0;
			end
			for (i = 0; i < HIST_DEPTH; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			wr_ptr = '0;
			expected_q.delete();
			error_total = 0;
			result_total = 0;
			clip_total = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_FF_COUNT)
					ff_count_q = cfg_data;
				else if (cfg_index == REG_FB_COUNT)
					fb_count_q = cfg_data;
			end

			// result transaction against oldest expectation
			if (result_valid && result_ready) begin
				result_total++;
				if (result.saturated)
					clip_total++;
				if (expected_q.size() == 0) begin
					error_total++;
					$display("%0t: unexpected result, expected none, actual %h/%b",
						$time, result.filtered, result.saturated);
				end else begin
					want = expected_q.pop_front();
					if (result.filtered !== want.filtered) begin
						error_total++;
						$display("%0t: filtered mismatch, expected %h, actual %h",
							$time, want.filtered, result.filtered);
					end
					if (result.saturated !== want.saturated) begin
						error_total++;
						$display("%0t: saturated mismatch, expected %b, actual %b",
							$time, want.saturated, result.saturated);
					end
				end
			end

			// item transaction updates the predictor
			if (item_valid && item_ready) begin
				case (item.kind)
					KIND_FILTER: begin
						want = filter_output(item.sample);
						expected_q.push_back(want);
						x_hist[wr_ptr] = item.sample;
						y_hist[wr_ptr] = want.filtered;
						wr_ptr = wr_ptr + HIST_AW'(1);
					end
					KIND_LOAD: begin
						if (item.coef_index <= 5'(MAX_ORDER)) begin
							if (item.coef_bank == BANK_FF)
								ff_coef[item.coef_index] = item.coef_value;
							else
								fb_coef[item.coef_index] = item.coef_value;
						end
					end
					KIND_CLEAR: begin
						for (i = 0; i < HIST_DEPTH; i++) begin
							x_hist[i] = '0;
							y_hist[i] = '0;
						end
						wr_ptr = '0;
					end
					default: begin
					end
				endcase
			end
		end
		mismatches <= error_total;
		pending <= expected_q.size();
		results_seen <= result_total;
		saturations <= clip_total;
	end

endmodule

>>> sim/tb_iir_direct_form_one_filter_unit.sv
// -----------------------------------------------------------------------------
// tb_iir_direct_form_one_filter_unit - testbench for the DF-I IIR filter unit
// Drives directed corner samples and loads, then randomized phases over many
// tap-count settings with random stalls on both channels and one long result
// hold; a checker beside the block predicts and compares every result.
// -----------------------------------------------------------------------------
module tb_iir_direct_form_one_filter_unit;
	import iirdf1_pkg::*;

	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam int         SETTLE_CYCLES = 64;
	localparam int         LONG_HOLD     = 400;
	localparam int         PHASES        = 8;
	localparam int         RANDOM_PHASE  = 6;
	localparam int         HOLD_PHASE    = 2;
	localparam int         PHASE_ITEMS   = 160;
	localparam int         FF_PLAN [PHASES] = '{21, 0, 31, 1, 21, 2, 0, 21};
	localparam int         FB_PLAN [PHASES] = '{21, 0, 31, 21, 1, 3, 0, 21};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;

	int mismatches;
	int pending;
	int results_seen;
	int saturations;

	// stall control shared with the receiver
	bit quiet = 1'b0;
	int idle_pct = 20;
	int hold_requests = 0;

	// run statistics
	int load_total = 0;
	int clear_total = 0;
	int ignored_total = 0;
	int setting_total = 0;

	iir_direct_form_one_filter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	iirdf1_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.saturations  (saturations)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stall bursts plus requested long holds
	initial begin : receiver
		int stall_left;
		int holds_served;
		stall_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && arst_n &&
					$urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// random Q8.24 value with magnitude at most 2^bits lsb
	function automatic logic signed [DATA_W-1:0] scaled_rand(int bits);
		logic signed [DATA_W-1:0] r;
		r = $urandom();
		return r >>> (31 - bits);
	endfunction

	// item with random content in every field
	function automatic item_t noise_item(logic [1:0] kind);
		item_t it;
		it.kind = kind;
		it.sample = $urandom();
		it.coef_bank = 1'($urandom_range(0, 1));
		it.coef_index = 5'($urandom_range(0, 31));
		it.coef_value = $urandom();
		return it;
	endfunction

	function automatic item_t sample_item(logic signed [DATA_W-1:0] x);
		item_t it;
		it = noise_item(KIND_FILTER);
		it.sample = x;
		return it;
	endfunction

	function automatic item_t load_item(logic bank, logic [4:0] idx,
			logic signed [DATA_W-1:0] v);
		item_t it;
		it = noise_item(KIND_LOAD);
		it.coef_bank = bank;
		it.coef_index = idx;
		it.coef_value = v;
		return it;
	endfunction

	// sample mix: mostly within +-1.0, some full range, some extremes
	function automatic logic signed [DATA_W-1:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return scaled_rand(24);
		if (roll < 85)
			return scaled_rand(31);
		case ($urandom_range(0, 4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	// one item transaction, with an optional idle burst first
	task automatic send(input item_t it);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		case (it.kind)
			KIND_LOAD: begin
				load_total++;
				if (it.coef_index > 5'(MAX_ORDER))
					ignored_total++;
			end
			KIND_CLEAR: clear_total++;
			KIND_UNUSED: ignored_total++;
			default: begin
			end
		endcase
	endtask

	// drain the block, let it settle, then write both tap counts
	task automatic set_counts(input logic [CNT_W-1:0] ff, input logic [CNT_W-1:0] fb);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FF_COUNT;
		cfg_data <= ff;
		@(posedge clk);
		cfg_index <= REG_FB_COUNT;
		cfg_data <= fb;
		@(posedge clk);
		cfg_we <= 1'b0;
		setting_total++;
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int p;
		int n;
		int k;
		int roll;
		int ff_bits;
		int fb_bits;
		logic [CNT_W-1:0] ff;
		logic [CNT_W-1:0] fb;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners with reset tap counts of one
		send(sample_item(32'sh1234_5678));
		send(load_item(BANK_FF, 5'd0, 32'sh7FFF_FFFF));
		send(sample_item(32'sh7FFF_FFFF));
		send(sample_item(32'sh8000_0000));
		send(load_item(BANK_FF, 5'd0, 32'sh8000_0000));
		send(sample_item(32'sh8000_0000));
		send(sample_item(32'sh7FFF_FFFF));
		// half lsb cases of the rounding
		send(load_item(BANK_FF, 5'd0, 32'sh0080_0000));
		send(sample_item(32'sd1));
		send(sample_item(-32'sd1));
		send(sample_item(32'sd3));
		// unity gain passes the extremes unclipped
		send(load_item(BANK_FF, 5'd0, 32'sh0100_0000));
		send(sample_item(32'sh8000_0000));
		send(sample_item(32'sh7FFF_FFFF));
		// a0 load, out-of-range indexes and the unused kind change nothing
		send(load_item(BANK_FB, 5'd0, 32'sh7FFF_FFFF));
		send(load_item(BANK_FF, 5'd21, 32'sh0200_0000));
		send(load_item(BANK_FB, 5'd31, 32'sh0200_0000));
		send(noise_item(KIND_UNUSED));
		send(sample_item(32'sh0040_0000));
		send(noise_item(KIND_CLEAR));
		send(sample_item(32'sh8000_0000));

		// random phases over tap-count settings
		for (p = 0; p < PHASES; p++) begin
			if (p == RANDOM_PHASE) begin
				ff = CNT_W'($urandom_range(0, 31));
				fb = CNT_W'($urandom_range(0, 31));
			end else begin
				ff = CNT_W'(FF_PLAN[p]);
				fb = CNT_W'(FB_PLAN[p]);
			end
			set_counts(ff, fb);
			if (p == PHASES - 1) begin
				quiet <= 1'b1;
				idle_pct <= 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct <= 0;
					1: idle_pct <= 10;
					2: idle_pct <= 30;
					default: idle_pct <= 60;
				endcase
			end

			// coefficient scale: gentle, moderate or full range
			case ($urandom_range(0, 2))
				0: begin ff_bits = 22; fb_bits = 19; end
				1: begin ff_bits = 27; fb_bits = 26; end
				default: begin ff_bits = 31; fb_bits = 31; end
			endcase
			for (k = 0; k < TAPS; k++) begin
				send(load_item(BANK_FF, 5'(k), scaled_rand(ff_bits)));
				send(load_item(BANK_FB, 5'(k), scaled_rand(fb_bits)));
			end

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == HOLD_PHASE && n == 20)
					hold_requests <= hold_requests + 1;
				roll = $urandom_range(0, 99);
				if (roll < 84)
					send(sample_item(pick_sample()));
				else if (roll < 91)
					send(load_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
						scaled_rand($urandom_range(0, 1) ? ff_bits : 31)));
				else if (roll < 95)
					send(noise_item(KIND_CLEAR));
				else
					send(noise_item(KIND_UNUSED));
			end
		end

		// drain and let the block go quiet
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d filtered samples (%0d clipped), %0d coefficient loads, %0d clears",
			results_seen, saturations, load_total, clear_total);
		$display("%0d ignored items, %0d tap-count settings from 0 to 31, one long result hold",
			ignored_total, setting_total);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
